@@ hdl/sensor_block_average_alarm_top_defines.svh @@
// ----------------------------------------------------------------------------
// sensor block average alarm - assertion macros
// shared property forms used by the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef SENSOR_BLOCK_AVERAGE_ALARM_TOP_DEFINES_SVH
`define SENSOR_BLOCK_AVERAGE_ALARM_TOP_DEFINES_SVH

// same-cycle implication
`define SBAA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbaa: same-cycle check failed");

// next-cycle implication
`define SBAA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbaa: next-cycle check failed");

`endif

@@ hdl/sbaa_pkg.sv @@
// ----------------------------------------------------------------------------
// sbaa_pkg
// fixed field widths, codes and shared types of the sensor average alarm
// ----------------------------------------------------------------------------
`default_nettype none

package sbaa_pkg;

    localparam int ID_W        = 16;
    localparam int VAL_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_FIELD_W = 51;
    localparam int OUT_DATA_W  = 56;

    typedef enum logic [0:0] {
        OP_MEAS = 1'b0,
        OP_REG  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT  = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2,
        ST_REG     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_TEMP = 1'b0,
        REG_MAX_TEMP = 1'b1
    } cfg_reg_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic rem_nz;
    } div_stat_t;

endpackage

`default_nettype wire

@@ hdl/sbaa_ram.sv @@
// ----------------------------------------------------------------------------
// sbaa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sbaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/sbaa_div.sv @@
// ----------------------------------------------------------------------------
// sbaa_div
// floored division of a signed window sum by the window length
// ----------------------------------------------------------------------------
`default_nettype none

module sbaa_div
    import sbaa_pkg::*;
#(
    parameter int SUM_W  = 19,
    parameter int WINDOW = 5
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend,
    output div_stat_t                    stat,
    output logic signed [SUM_W-1:0]      quotient
);

    // reciprocal scaled so that the truncated product is the exact quotient
    // for every magnitude that fits in SUM_W bits
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int SHIFT   = SUM_W + LOG_W;
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [SUM_W-1:0]   DIVISOR = SUM_W'(WINDOW);

    logic              run_reg;
    logic              fix_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  qmag_reg, qmag_next;
    logic              nz_reg, nz_next;
    logic [SUM_W-1:0]  quot_reg, quot_next;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  qmag;
    logic [SUM_W-1:0]  back;
    logic              rem_nz;

    // quotient of the magnitude, then the remainder check against it
    always_comb
    begin
        prod   = PROD_W'(mag_reg) * PROD_W'(RECIP);
        qmag   = SUM_W'(prod >> SHIFT);
        back   = qmag_reg * DIVISOR;
        rem_nz = (back != mag_reg);
    end

    always_comb
    begin
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        qmag_next = qmag_reg;
        nz_next   = nz_reg;
        quot_next = quot_reg;

        if (start)
        begin
            neg_next = dividend[SUM_W-1];
            mag_next = dividend[SUM_W-1] ? (-dividend) : dividend;
        end
        if (run_reg)
        begin
            qmag_next = qmag;
        end
        if (fix_reg)
        begin
            // floor toward minus infinity for a negative sum
            nz_next   = rem_nz;
            quot_next = neg_reg ? (-(qmag_reg + SUM_W'(rem_nz))) : qmag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= start;
            fix_reg  <= run_reg;
            done_reg <= fix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        qmag_reg <= qmag_next;
        nz_reg   <= nz_next;
        quot_reg <= quot_next;
    end

    assign stat.done   = done_reg;
    assign stat.rem_nz = nz_reg;
    assign quotient    = $signed(quot_reg);

endmodule

`default_nettype wire

@@ hdl/sensor_block_average_alarm_top.sv @@
// ----------------------------------------------------------------------------
// sensor_block_average_alarm_top
// sensor table with windowed block average and cold/hot threshold alarm
//
//   channel   direction  signals                       content
//   s_axis    in         s_tvalid s_tready s_tdata/user  register or measurement
//   m_axis    out        m_tvalid m_tready m_tdata/user  status, flags, average
//   cfg       in         cfg_we cfg_index cfg_data      min_temp, max_temp
//
// one transaction at a time: the table ram is scanned one entry per cycle,
// so a transaction that hits entry k stops the scan at that entry, while a miss
// or a new registration scans all MAX_SENSORS entries; after the scan a
// registration passes S_EVAL and S_DONE, a hit measurement S_EVAL, S_UPD and S_DONE
// a measurement that closes a full window also waits in S_DIV for the divider
// the result waits in an output register; a stalled output holds the next
// transaction in its final step. reset clears all valid bits at once
// ----------------------------------------------------------------------------
`default_nettype none
`include "sensor_block_average_alarm_top_defines.svh"

module sensor_block_average_alarm_top
    import sbaa_pkg::*;
#(
    parameter int MAX_SENSORS = 16,
    parameter int WINDOW      = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slave stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // probe_id, room_id, value
    input  wire logic [0:0]            s_tuser,   // op
    // master stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // too_cold, too_hot, avg_valid, average, out_probe_id, out_room_id, pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [STATUS_W-1:0]        m_tuser,   // status
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SUM_W   = VAL_W + $clog2(WINDOW);
    localparam int RID_LSB = ID_W;
    localparam int CNT_LSB = 2 * ID_W;
    localparam int SUM_LSB = 2 * ID_W + CNT_W;
    localparam int ENT_W   = 2 * ID_W + CNT_W + SUM_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SENSORS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_EVAL = 6'b000100,
        S_DIV  = 6'b001000,
        S_UPD  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic                     issue_reg, issue_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic                     hit_reg, hit_next;
    logic                     free_reg, free_next;
    logic [MAX_SENSORS-1:0]   valid_reg, valid_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [VAL_W-1:0]  min_reg;
    logic signed [VAL_W-1:0]  max_reg;

    logic                     op_reg, op_next;
    logic [ID_W-1:0]          sid_reg, sid_next;
    logic [ID_W-1:0]          rid_reg, rid_next;
    logic signed [VAL_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]         scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [ID_W-1:0]          hit_room_reg, hit_room_next;
    logic [CNT_W-1:0]         upd_cnt_reg, upd_cnt_next;
    logic signed [SUM_W-1:0]  upd_sum_reg, upd_sum_next;
    status_t                  res_status_reg, res_status_next;
    logic                     res_cold_reg, res_cold_next;
    logic                     res_hot_reg, res_hot_next;
    logic                     res_avalid_reg, res_avalid_next;
    logic signed [VAL_W-1:0]  res_avg_reg, res_avg_next;
    logic [ID_W-1:0]          res_room_reg, res_room_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;
    logic [STATUS_W-1:0]      out_user_reg, out_user_next;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ENT_W-1:0]         ram_wdata;
    logic [ENT_W-1:0]         ram_rdata;
    logic [ID_W-1:0]          rd_sid;
    logic [ID_W-1:0]          rd_room;
    logic [CNT_W-1:0]         rd_cnt;
    logic signed [SUM_W-1:0]  rd_sum;

    logic                     div_start;
    div_stat_t                div_stat;
    logic signed [SUM_W-1:0]  div_q;
    logic signed [SUM_W-1:0]  min_ext;
    logic signed [SUM_W-1:0]  max_ext;
    logic [IDX_W-1:0]         reg_idx;
    logic                     out_miss;

    sbaa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SENSORS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    sbaa_div #(
        .SUM_W  (SUM_W),
        .WINDOW (WINDOW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (upd_sum_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign rd_sid  = ram_rdata[ID_W-1:0];
    assign rd_room = ram_rdata[RID_LSB +: ID_W];
    assign rd_cnt  = ram_rdata[CNT_LSB +: CNT_W];
    assign rd_sum  = $signed(ram_rdata[SUM_LSB +: SUM_W]);
    assign min_ext = SUM_W'(min_reg);
    assign max_ext = SUM_W'(max_reg);
    assign reg_idx = hit_reg ? hit_idx_reg : free_idx_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        hit_next        = hit_reg;
        free_next       = free_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        op_next         = op_reg;
        sid_next        = sid_reg;
        rid_next        = rid_reg;
        val_next        = val_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        hit_room_next   = hit_room_reg;
        upd_cnt_next    = upd_cnt_reg;
        upd_sum_next    = upd_sum_reg;
        res_status_next = res_status_reg;
        res_cold_next   = res_cold_reg;
        res_hot_next    = res_hot_reg;
        res_avalid_next = res_avalid_reg;
        res_avg_next    = res_avg_reg;
        res_room_next   = res_room_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = {upd_sum_reg, upd_cnt_reg, hit_room_reg, sid_reg};
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = s_tuser[0];
                    sid_next        = s_tdata[ID_W-1:0];
                    rid_next        = s_tdata[ID_W +: ID_W];
                    val_next        = $signed(s_tdata[2*ID_W +: VAL_W]);
                    scan_idx_next   = '0;
                    issue_next      = 1'b1;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    res_cold_next   = 1'b0;
                    res_hot_next    = 1'b0;
                    res_avalid_next = 1'b0;
                    res_avg_next    = '0;
                    res_room_next   = '0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // the compare sees the entry whose read was issued in the previous cycle
                cmp_vld_next = issue_reg;
                cmp_idx_next = scan_idx_reg;
                if (issue_reg)
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (cmp_vld_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && (rd_sid == sid_reg))
                    begin
                        hit_next      = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                        hit_room_next = rd_room;
                        upd_cnt_next  = rd_cnt;
                        upd_sum_next  = rd_sum;
                        state_next    = S_EVAL;
                    end
                    else
                    begin
                        if (!valid_reg[cmp_idx_reg] && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_next = S_EVAL;
                        end
                    end
                end
            end

            S_EVAL:
            begin
                state_next = S_DONE;
                if (op_reg == OP_REG)
                begin
                    if (hit_reg || free_reg)
                    begin
                        ram_we              = 1'b1;
                        ram_waddr           = reg_idx;
                        ram_wdata           = {{SUM_W{1'b0}}, {CNT_W{1'b0}}, rid_reg, sid_reg};
                        valid_next[reg_idx] = 1'b1;
                        res_status_next     = ST_REG;
                        res_room_next       = rid_reg;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
                else if (!hit_reg)
                begin
                    res_status_next = ST_UNKNOWN;
                end
                else
                begin
                    res_status_next = ST_ACCEPT;
                    res_room_next   = hit_room_reg;
                    if (upd_cnt_reg >= FULL_CNT)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_UPD;
                    end
                end
            end

            S_DIV:
            begin
                if (div_stat.done)
                begin
                    // floor compares give the exact-average thresholds
                    res_avalid_next = 1'b1;
                    res_avg_next    = div_q[VAL_W-1:0];
                    res_cold_next   = (div_q < min_ext);
                    res_hot_next    = (div_q > max_ext) ||
                                      ((div_q == max_ext) && div_stat.rem_nz);
                    upd_cnt_next    = '0;
                    upd_sum_next    = '0;
                    state_next      = S_UPD;
                end
            end

            S_UPD:
            begin
                ram_we = 1'b1;
                if (val_reg != '0)
                begin
                    ram_wdata = {upd_sum_reg + SUM_W'(val_reg), upd_cnt_reg + 1'b1,
                                 hit_room_reg, sid_reg};
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_data_next = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, res_room_reg,
                                     sid_reg, res_avg_reg, res_avalid_reg, res_hot_reg,
                                     res_cold_reg};
                    out_user_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issue_reg   <= 1'b0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            min_reg     <= '0;
            max_reg     <= 16'sh7FFF;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_TEMP: min_reg <= $signed(cfg_data);
                    REG_MAX_TEMP: max_reg <= $signed(cfg_data);
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        sid_reg        <= sid_next;
        rid_reg        <= rid_next;
        val_reg        <= val_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        hit_room_reg   <= hit_room_next;
        upd_cnt_reg    <= upd_cnt_next;
        upd_sum_reg    <= upd_sum_next;
        res_status_reg <= res_status_next;
        res_cold_reg   <= res_cold_next;
        res_hot_reg    <= res_hot_next;
        res_avalid_reg <= res_avalid_next;
        res_avg_reg    <= res_avg_next;
        res_room_reg   <= res_room_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
    end

    // unknown sensor or full table on the output
    assign out_miss = m_tvalid && ((m_tuser == ST_UNKNOWN) || (m_tuser == ST_FULL));

    `SBAA_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_stat.done, state_reg == S_DIV)
    `SBAA_ASSERT_NXT(a_accept_starts_scan, clk, rst_n, s_tvalid && s_tready, state_reg == S_SCAN)
    `SBAA_ASSERT_IMP(a_avg_only_on_accept, clk, rst_n, m_tvalid && m_tdata[2], m_tuser == ST_ACCEPT)
    `SBAA_ASSERT_IMP(a_no_room_on_miss, clk, rst_n, out_miss, m_tdata[50:35] == '0)

endmodule

`default_nettype wire

@@ test/sensor_block_average_alarm_top_tb.sv @@
// ----------------------------------------------------------------------------
// sensor_block_average_alarm_top_tb
// self-checking bench: drives register and measurement transactions through
// the input stream, predicts every result from a local copy of the sensor
// table and compares each output transaction field by field, across several
// threshold settings, random idling on both sides and one long run of output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_block_average_alarm_top_tb;
    import sbaa_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int AVG_WINDOW   = 5;
    localparam int ID_POOL      = 24;
    localparam int PHASE_ITEMS  = 330;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 60;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        op_t                     op;
        logic [ID_W-1:0]         probe_id;
        logic [ID_W-1:0]         room_id;
        logic signed [VAL_W-1:0] value;
    } sensor_cmd_t;

    typedef struct packed {
        status_t          status;
        logic             too_cold;
        logic             too_hot;
        logic             avg_valid;
        logic [VAL_W-1:0] average;
        logic [ID_W-1:0]  probe_id;
        logic [ID_W-1:0]  room_id;
    } alarm_result_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata    = '0;
    logic [0:0]           s_tuser    = '0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;

    // local copy of the sensor table and thresholds
    bit                   tbl_valid [TABLE_DEPTH];
    logic [ID_W-1:0]      tbl_sid   [TABLE_DEPTH];
    logic [ID_W-1:0]      tbl_room  [TABLE_DEPTH];
    int                   tbl_count [TABLE_DEPTH];
    int                   tbl_sum   [TABLE_DEPTH];
    int                   min_thr = 0;
    int                   max_thr = 32767;

    sensor_cmd_t          pending_cmds[$];
    alarm_result_t        predicted_results[$];
    sensor_cmd_t          active_cmd;
    alarm_result_t        want;
    logic [ID_W-1:0]      id_pool [ID_POOL];

    bit                   cmd_sent  = 1'b0;
    bit                   calm      = 1'b0;
    bit                   hold_req  = 1'b0;
    int                   hold_left = 0;
    int                   errors    = 0;
    int                   cycles    = 0;

    sensor_block_average_alarm_top #(
        .MAX_SENSORS (TABLE_DEPTH),
        .WINDOW      (AVG_WINDOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic alarm_result_t update_sensor_table(input sensor_cmd_t c);
        alarm_result_t r;
        int            slot;
        int            i;
        int            s;
        int            avg;
        r           = '0;
        r.status    = ST_ACCEPT;
        r.probe_id  = c.probe_id;
        slot        = -1;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (slot < 0 && tbl_valid[i] && tbl_sid[i] == c.probe_id)
                slot = i;
        if (c.op == OP_REG)
        begin
            for (i = 0; i < TABLE_DEPTH; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
            if (slot < 0)
                r.status = ST_FULL;
            else
            begin
                tbl_valid[slot] = 1'b1;
                tbl_sid[slot]   = c.probe_id;
                tbl_room[slot]  = c.room_id;
                tbl_count[slot] = 0;
                tbl_sum[slot]   = 0;
                r.status        = ST_REG;
                r.room_id       = c.room_id;
            end
        end
        else if (slot < 0)
            r.status = ST_UNKNOWN;
        else
        begin
            r.room_id = tbl_room[slot];
            if (tbl_count[slot] >= AVG_WINDOW)
            begin
                s   = tbl_sum[slot];
                avg = s / AVG_WINDOW;
                // floor toward minus infinity, not toward zero
                if (s % AVG_WINDOW != 0 && s < 0)
                    avg = avg - 1;
                r.average   = avg[VAL_W-1:0];
                r.too_cold  = s < min_thr * AVG_WINDOW;
                r.too_hot   = s > max_thr * AVG_WINDOW;
                r.avg_valid = 1'b1;
                tbl_count[slot] = 0;
                tbl_sum[slot]   = 0;
            end
            if (c.value != 0)
            begin
                tbl_sum[slot]   = tbl_sum[slot] + int'($signed(c.value));
                tbl_count[slot] = tbl_count[slot] + 1;
            end
        end
        return r;
    endfunction

    function automatic sensor_cmd_t make_cmd(input op_t op, input logic [ID_W-1:0] sid,
                                             input logic [ID_W-1:0] rid, input int val);
        sensor_cmd_t c;
        c.op        = op;
        c.probe_id  = sid;
        c.room_id   = rid;
        c.value     = val[VAL_W-1:0];
        return c;
    endfunction

    function automatic sensor_cmd_t random_cmd();
        int          roll;
        int          vroll;
        int          val;
        logic [ID_W-1:0] sid;
        op_t         op;
        roll  = $urandom_range(99);
        vroll = $urandom_range(99);
        sid   = id_pool[$urandom_range(ID_POOL - 1)];
        op    = OP_MEAS;
        if (roll < 8)
            op = OP_REG;
        else if (roll < 10)
        begin
            op  = OP_REG;
            sid = ID_W'($urandom_range(16'hFFFF));
        end
        else if (roll < 15)
            sid = ID_W'($urandom_range(16'hFFFF));
        if (vroll < 10)
            val = 0;
        else if (vroll < 18)
            val = $urandom_range(1) ? 32767 : -32768;
        else if (vroll < 50)
            val = int'($urandom_range(400)) - 200;
        else
            val = $urandom_range(16'hFFFF);
        return make_cmd(op, sid, ID_W'($urandom_range(16'hFFFF)), val);
    endfunction

    task automatic write_thresholds(input int lo, input int hi);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = REG_MIN_TEMP;
        cfg_data  = lo[CFG_W-1:0];
        @(negedge clk);
        cfg_index = REG_MAX_TEMP;
        cfg_data  = hi[CFG_W-1:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        min_thr   = int'($signed(lo[CFG_W-1:0]));
        max_thr   = int'($signed(hi[CFG_W-1:0]));
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [VAL_W-1:0] exp_v,
                                 input logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || cmd_sent))
        begin
            cmd_sent = 1'b0;
            if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= 14))
            begin
                active_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {active_cmd.value, active_cmd.room_id, active_cmd.probe_id};
                s_tuser  <= active_cmd.op;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output receiver, with the long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || $urandom_range(99) >= 14;
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
        if (m_tvalid && m_tready)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                compare_field("status",    VAL_W'(want.status),    VAL_W'(m_tuser));
                compare_field("too_cold",  VAL_W'(want.too_cold),  VAL_W'(m_tdata[0]));
                compare_field("too_hot",   VAL_W'(want.too_hot),   VAL_W'(m_tdata[1]));
                compare_field("avg_valid", VAL_W'(want.avg_valid), VAL_W'(m_tdata[2]));
                compare_field("average",   want.average,   m_tdata[18:3]);
                compare_field("probe_id",  want.probe_id,  m_tdata[34:19]);
                compare_field("room_id",   want.room_id,   m_tdata[50:35]);
            end
        end
        if (s_tvalid && s_tready)
        begin
            predicted_results.push_back(update_sensor_table(active_cmd));
            cmd_sent = 1'b1;
        end
    end

    initial
    begin
        int phase;
        int n;
        int lo_set [NUM_PHASES];
        int hi_set [NUM_PHASES];
        lo_set = '{-32768, 32767, 0, -300, 0, 0};
        hi_set = '{ 32767, -32768, 0,  300, 0, 32767};
        lo_set[4] = $urandom_range(16'hFFFF);
        hi_set[4] = $urandom_range(16'hFFFF);
        for (n = 0; n < ID_POOL; n++)
            id_pool[n] = ID_W'($urandom_range(16'hFFFF));
        for (n = 0; n < TABLE_DEPTH; n++)
        begin
            tbl_valid[n] = 1'b0;
            tbl_count[n] = 0;
            tbl_sum[n]   = 0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, unknown id, replace, zero reading, floored average
        write_thresholds(-10, 10);
        pending_cmds.push_back(make_cmd(OP_MEAS, 16'hFFFF, 16'hFFFF, 32767));
        pending_cmds.push_back(make_cmd(OP_REG,  16'h0000, 16'hFFFF, 0));
        pending_cmds.push_back(make_cmd(OP_REG,  16'hFFFF, 16'h0000, -32768));
        repeat (5) pending_cmds.push_back(make_cmd(OP_MEAS, 16'h0000, 16'h0000, 32767));
        pending_cmds.push_back(make_cmd(OP_MEAS, 16'h0000, 16'h0000, 0));
        pending_cmds.push_back(make_cmd(OP_MEAS, 16'hFFFF, 16'h0000, -32768));
        repeat (4) pending_cmds.push_back(make_cmd(OP_MEAS, 16'hFFFF, 16'h0000, -1));
        pending_cmds.push_back(make_cmd(OP_MEAS, 16'hFFFF, 16'h0000, -7));
        pending_cmds.push_back(make_cmd(OP_REG,  16'hFFFF, 16'h5555, 0));
        pending_cmds.push_back(make_cmd(OP_MEAS, 16'hFFFF, 16'hAAAA, 1));
        repeat (4) pending_cmds.push_back(make_cmd(OP_MEAS, 16'hFFFF, 16'h0000, 2));
        pending_cmds.push_back(make_cmd(OP_MEAS, 16'hFFFF, 16'h0000, 0));
        wait_drained();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_thresholds(lo_set[phase], hi_set[phase]);
            calm = (phase == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_cmds.push_back(random_cmd());
            if (phase == 1)
                hold_req = 1'b1;
            wait_drained();
        end

        calm = 1'b0;
        repeat (SETTLE) @(negedge clk);
        if (errors == 0 && predicted_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
